### rtl/lru_k_frame_replacer_core_macros.svh
// Assertion macros shared by the replacer checker.
`ifndef LRU_K_FRAME_REPLACER_CORE_MACROS_SVH
`define LRU_K_FRAME_REPLACER_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LRUKFR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Check a consequence in the same cycle.
`define LRUKFR_ASSERT_NOW(label, ante, cons, msg) \
   `LRUKFR_ASSERT(label, (ante) |-> (cons), msg)

// Check a consequence in the next cycle.
`define LRUKFR_ASSERT_NEXT(label, ante, cons, msg) \
   `LRUKFR_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/lrukfr_pkg.sv
// Shared constants, types and helper functions of the LRU-K frame replacer.
`timescale 1ns / 1ps

package lrukfr_pkg;

   localparam int FRAME_COUNT = 64;
   localparam int K_MAX       = 8;
   localparam int STAMP_WIDTH = 32;

   localparam int FRAME_W     = $clog2(FRAME_COUNT);
   localparam int HEAD_W      = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int CNT_W       = $clog2(K_MAX + 1);
   localparam int STAMP_DEPTH = FRAME_COUNT * K_MAX;
   localparam int STAMP_AW    = (STAMP_DEPTH > 1) ? $clog2(STAMP_DEPTH) : 1;
   localparam int SCAN_W      = $clog2(FRAME_COUNT + 3);

   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int KVAL_W      = 4;
   localparam int FIU_W       = 7;
   localparam int EVC_W       = 7;
   localparam int REQ_W       = 8;
   localparam int RSP_W       = 16;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int CSR_IDX_BIT = 2;

   localparam logic [OP_W-1:0] OP_RECORD    = 2'd0;
   localparam logic [OP_W-1:0] OP_SET_EVICT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE    = 2'd2;
   localparam logic [OP_W-1:0] OP_EVICT     = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PINNED    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

   localparam logic REG_K_VALUE       = 1'b0;
   localparam logic REG_FRAMES_IN_USE = 1'b1;

   typedef struct packed {
      logic                pad;
      logic                evictable_flag;
      logic [FRAME_W-1:0]  frame_sel;
   } req_data_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [EVC_W-1:0]    evictable_count;
      logic [FRAME_W-1:0]  victim_frame;
      logic                victim_valid;
   } rsp_data_type;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [HEAD_W-1:0] head;
   } meta_type;

   function automatic logic [CNT_W-1:0] eff_k(input logic [KVAL_W-1:0] kv);
      logic [CNT_W-1:0] k;
      if (kv == '0) begin
         k = CNT_W'(1);
      end else if (int'(kv) > K_MAX) begin
         k = CNT_W'(K_MAX);
      end else begin
         k = CNT_W'(kv);
      end
      return k;
   endfunction

   function automatic logic [STAMP_AW-1:0] stamp_addr(input logic [FRAME_W-1:0] f,
                                                     input logic [HEAD_W-1:0] slot);
      return STAMP_AW'(f) * STAMP_AW'(K_MAX) + STAMP_AW'(slot);
   endfunction

endpackage

### rtl/lrukfr_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module lrukfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/lru_k_frame_replacer_core.sv
// LRU-K frame replacer: per-frame access history, evictable tracking and victim scan.
`timescale 1ns / 1ps

// One request is in work at a time; req_tready is high only while the block is idle.
// Record access, set evictable and remove go from acceptance to the result on
// rsp_tdata through one metadata RAM read, one update step and one output load.
// In an evict the scan streams one frame per cycle through the metadata RAM read
// port, then the stamp RAM read port, into a single compare unit that keeps the
// best candidate, so its length is set by FRAME_COUNT and the two-deep read
// pipeline. The result register frees the request side, so a new request is
// taken while a result waits. Stamp storage is not cleared; a frame's history
// is valid only while it is present. No clearing pass follows reset.
module lru_k_frame_replacer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lrukfr_pkg::REQ_W-1:0]     req_tdata,   // frame number, evictable_flag
   input  logic [lrukfr_pkg::OP_W-1:0]      req_tuser,   // opcode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lrukfr_pkg::RSP_W-1:0]     rsp_tdata,   // victim_valid, victim_frame,
                                                         // evictable_count, status
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lrukfr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [lrukfr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [lrukfr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                             csr_pready
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_META = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   localparam int NF = lrukfr_pkg::FRAME_COUNT;

   logic [2:0]                             state_ff, state_in;
   logic [lrukfr_pkg::OP_W-1:0]            op_ff, op_in;
   logic [lrukfr_pkg::FRAME_W-1:0]         frame_ff, frame_in;
   logic                                   flag_ff, flag_in;
   logic [NF-1:0]                          present_ff, present_in;
   logic [NF-1:0]                          evict_ff, evict_in;
   logic [lrukfr_pkg::EVC_W-1:0]           total_ff, total_in;
   logic [lrukfr_pkg::STAMP_WIDTH-1:0]     aclk_ff, aclk_in;
   logic [lrukfr_pkg::KVAL_W-1:0]          kval_ff, kval_in;
   logic [lrukfr_pkg::FIU_W-1:0]           fiu_ff, fiu_in;
   logic [lrukfr_pkg::SCAN_W-1:0]          scan_ff, scan_in;
   logic                                   p1_vld_ff, p1_vld_in;
   logic [lrukfr_pkg::FRAME_W-1:0]         p1_frame_ff, p1_frame_in;
   logic                                   p2_vld_ff, p2_vld_in;
   logic [lrukfr_pkg::FRAME_W-1:0]         p2_frame_ff, p2_frame_in;
   logic                                   p2_inf_ff, p2_inf_in;
   logic                                   best_found_ff, best_found_in;
   logic                                   best_inf_ff, best_inf_in;
   logic [lrukfr_pkg::STAMP_WIDTH-1:0]     best_stamp_ff, best_stamp_in;
   logic [lrukfr_pkg::FRAME_W-1:0]         best_frame_ff, best_frame_in;
   lrukfr_pkg::rsp_data_type               res_ff, res_in;
   lrukfr_pkg::rsp_data_type               rsp_data_ff, rsp_data_in;
   logic                                   rsp_valid_ff, rsp_valid_in;

   logic                                   meta_we;
   logic [lrukfr_pkg::FRAME_W-1:0]         meta_raddr;
   lrukfr_pkg::meta_type                   meta_wdata, meta_rdata, cur_meta;
   logic                                   stamp_we;
   logic [lrukfr_pkg::STAMP_AW-1:0]        stamp_waddr, stamp_raddr;
   logic [lrukfr_pkg::STAMP_WIDTH-1:0]     stamp_rdata;

   lrukfr_pkg::req_data_type               req_fields;
   logic                                   csr_wr;
   logic [lrukfr_pkg::CNT_W-1:0]           effk, s1_m, s1_idx_full;
   logic                                   s1_inf, take, cur_present, in_range;
   logic [lrukfr_pkg::FIU_W-1:0]           fiu_lim;
   logic [lrukfr_pkg::HEAD_W-1:0]          s1_idx;

   lrukfr_ram #(
      .WIDTH ($bits(lrukfr_pkg::meta_type)),
      .DEPTH (NF)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (frame_ff),
      .wdata (meta_wdata),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   lrukfr_ram #(
      .WIDTH (lrukfr_pkg::STAMP_WIDTH),
      .DEPTH (lrukfr_pkg::STAMP_DEPTH)
   ) u_stamp_ram (
      .clock (clock),
      .we    (stamp_we),
      .waddr (stamp_waddr),
      .wdata (aclk_ff),
      .raddr (stamp_raddr),
      .rdata (stamp_rdata)
   );

   assign req_fields = req_tdata;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[lrukfr_pkg::CSR_IDX_BIT] == lrukfr_pkg::REG_FRAMES_IN_USE)
                       ? lrukfr_pkg::CSR_DW'(fiu_ff) : lrukfr_pkg::CSR_DW'(kval_ff);

   assign effk        = lrukfr_pkg::eff_k(kval_ff);
   assign meta_raddr  = (state_ff == S_SCAN) ? scan_ff[lrukfr_pkg::FRAME_W-1:0] : frame_ff;
   assign cur_present = present_ff[frame_ff];
   assign cur_meta    = cur_present ? meta_rdata : '0;
   assign fiu_lim     = (fiu_ff < lrukfr_pkg::FIU_W'(NF)) ? fiu_ff : lrukfr_pkg::FIU_W'(NF);
   assign in_range    = (lrukfr_pkg::FIU_W'(frame_ff) < fiu_lim);

   // Scan stage 1: reference slot of the frame read from metadata last cycle.
   assign s1_inf      = (meta_rdata.count < effk);
   assign s1_m        = s1_inf ? meta_rdata.count : effk;
   assign s1_idx_full = (lrukfr_pkg::CNT_W'(meta_rdata.head) >= s1_m)
                        ? lrukfr_pkg::CNT_W'(meta_rdata.head) - s1_m
                        : lrukfr_pkg::CNT_W'(meta_rdata.head)
                          + lrukfr_pkg::CNT_W'(lrukfr_pkg::K_MAX) - s1_m;
   assign s1_idx      = s1_idx_full[lrukfr_pkg::HEAD_W-1:0];
   assign stamp_raddr = lrukfr_pkg::stamp_addr(p1_frame_ff, s1_idx);

   // Scan stage 2: shared compare against the best candidate so far.
   assign take = p2_vld_ff && (!best_found_ff || (p2_inf_ff && !best_inf_ff) ||
                 ((p2_inf_ff == best_inf_ff) && (stamp_rdata < best_stamp_ff)));

   assign stamp_waddr = lrukfr_pkg::stamp_addr(frame_ff, cur_meta.head);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      frame_in      = frame_ff;
      flag_in       = flag_ff;
      present_in    = present_ff;
      evict_in      = evict_ff;
      total_in      = total_ff;
      aclk_in       = aclk_ff;
      kval_in       = kval_ff;
      fiu_in        = fiu_ff;
      scan_in       = scan_ff;
      p1_vld_in     = 1'b0;
      p1_frame_in   = scan_ff[lrukfr_pkg::FRAME_W-1:0];
      p2_vld_in     = p1_vld_ff;
      p2_frame_in   = p1_frame_ff;
      p2_inf_in     = s1_inf;
      best_found_in = best_found_ff;
      best_inf_in   = best_inf_ff;
      best_stamp_in = best_stamp_ff;
      best_frame_in = best_frame_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      meta_we       = 1'b0;
      stamp_we      = 1'b0;
      meta_wdata.count = (cur_meta.count < lrukfr_pkg::CNT_W'(lrukfr_pkg::K_MAX))
                         ? cur_meta.count + lrukfr_pkg::CNT_W'(1) : cur_meta.count;
      meta_wdata.head  = (cur_meta.head == lrukfr_pkg::HEAD_W'(lrukfr_pkg::K_MAX - 1))
                         ? '0 : cur_meta.head + lrukfr_pkg::HEAD_W'(1);

      if (csr_wr) begin
         if (csr_paddr[lrukfr_pkg::CSR_IDX_BIT] == lrukfr_pkg::REG_K_VALUE) begin
            kval_in = csr_pwdata[lrukfr_pkg::KVAL_W-1:0];
         end else begin
            fiu_in = csr_pwdata[lrukfr_pkg::FIU_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = req_tuser;
               frame_in      = req_fields.frame_sel;
               flag_in       = req_fields.evictable_flag;
               scan_in       = '0;
               best_found_in = 1'b0;
               p2_vld_in     = 1'b0;
               state_in      = (req_tuser == lrukfr_pkg::OP_EVICT) ? S_SCAN : S_META;
            end
         end
         S_META: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            res_in = '0;
            if (!in_range) begin
               res_in.status = lrukfr_pkg::ST_RANGE;
            end else begin
               case (op_ff)
                  lrukfr_pkg::OP_RECORD: begin
                     if (aclk_ff == '1) begin
                        res_in.status = lrukfr_pkg::ST_EXHAUSTED;
                     end else begin
                        present_in[frame_ff] = 1'b1;
                        meta_we  = 1'b1;
                        stamp_we = 1'b1;
                        aclk_in  = aclk_ff + lrukfr_pkg::STAMP_WIDTH'(1);
                     end
                  end
                  lrukfr_pkg::OP_SET_EVICT: begin
                     if (cur_present && flag_ff && !evict_ff[frame_ff]) begin
                        evict_in[frame_ff] = 1'b1;
                        total_in = total_ff + lrukfr_pkg::EVC_W'(1);
                     end else if (cur_present && !flag_ff && evict_ff[frame_ff]) begin
                        evict_in[frame_ff] = 1'b0;
                        total_in = total_ff - lrukfr_pkg::EVC_W'(1);
                     end
                  end
                  lrukfr_pkg::OP_REMOVE: begin
                     if (cur_present && !evict_ff[frame_ff]) begin
                        res_in.status = lrukfr_pkg::ST_PINNED;
                     end else if (cur_present) begin
                        present_in[frame_ff] = 1'b0;
                        evict_in[frame_ff]   = 1'b0;
                        total_in = total_ff - lrukfr_pkg::EVC_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            res_in.evictable_count = total_in;
            state_in = S_DONE;
         end
         S_SCAN: begin
            scan_in = scan_ff + lrukfr_pkg::SCAN_W'(1);
            if (scan_ff < lrukfr_pkg::SCAN_W'(NF)) begin
               p1_vld_in = present_ff[scan_ff[lrukfr_pkg::FRAME_W-1:0]] &&
                           evict_ff[scan_ff[lrukfr_pkg::FRAME_W-1:0]];
            end
            if (take) begin
               best_found_in = 1'b1;
               best_inf_in   = p2_inf_ff;
               best_stamp_in = stamp_rdata;
               best_frame_in = p2_frame_ff;
            end
            if (scan_ff == lrukfr_pkg::SCAN_W'(NF + 2)) begin
               res_in = '0;
               if (best_found_ff) begin
                  present_in[best_frame_ff] = 1'b0;
                  evict_in[best_frame_ff]   = 1'b0;
                  total_in = total_ff - lrukfr_pkg::EVC_W'(1);
                  res_in.victim_valid = 1'b1;
                  res_in.victim_frame = best_frame_ff;
               end
               res_in.evictable_count = total_in;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         present_ff    <= '0;
         evict_ff      <= '0;
         total_ff      <= '0;
         aclk_ff       <= '0;
         kval_ff       <= lrukfr_pkg::KVAL_W'(2);
         fiu_ff        <= lrukfr_pkg::FIU_W'(64);
         rsp_valid_ff  <= 1'b0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         present_ff    <= present_in;
         evict_ff      <= evict_in;
         total_ff      <= total_in;
         aclk_ff       <= aclk_in;
         kval_ff       <= kval_in;
         fiu_ff        <= fiu_in;
         rsp_valid_ff  <= rsp_valid_in;
         p1_vld_ff     <= p1_vld_in;
         p2_vld_ff     <= p2_vld_in;
         best_found_ff <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      frame_ff      <= frame_in;
      flag_ff       <= flag_in;
      scan_ff       <= scan_in;
      p1_frame_ff   <= p1_frame_in;
      p2_frame_ff   <= p2_frame_in;
      p2_inf_ff     <= p2_inf_in;
      best_inf_ff   <= best_inf_in;
      best_stamp_ff <= best_stamp_in;
      best_frame_ff <= best_frame_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

### rtl/lrukfr_checker.sv
// Port-level checks of the LRU-K frame replacer, bound to the top level.
`timescale 1ns / 1ps
`include "lru_k_frame_replacer_core_macros.svh"

module lrukfr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [lrukfr_pkg::RSP_W-1:0]  rsp_tdata
);

   lrukfr_pkg::rsp_data_type rsp_fields;
   logic                     req_xact;
   logic                     rsp_stall;
   logic                     rsp_hit;
   logic                     rsp_miss;
   logic                     count_ok;

   assign rsp_fields = rsp_tdata;
   assign req_xact   = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_hit    = rsp_tvalid && rsp_fields.victim_valid;
   assign rsp_miss   = rsp_tvalid && !rsp_fields.victim_valid;
   assign count_ok   = int'(rsp_fields.evictable_count) <= lrukfr_pkg::FRAME_COUNT;

   `LRUKFR_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "rsp not held")
   `LRUKFR_ASSERT_NEXT(a_busy_after_req, req_xact, !req_tready, "request taken while busy")
   `LRUKFR_ASSERT_NOW(a_no_victim_zero, rsp_miss, rsp_fields.victim_frame == '0, "stray frame")
   `LRUKFR_ASSERT_NOW(a_victim_ok, rsp_hit, rsp_fields.status == lrukfr_pkg::ST_OK, "bad status")
   `LRUKFR_ASSERT_NOW(a_count_bound, rsp_tvalid, count_ok, "evictable count above frame count")

endmodule

bind lru_k_frame_replacer_core lrukfr_checker u_lrukfr_checker (.*);
